@@ hdl/sha1sh_pkg.sv @@
`timescale 1ns / 1ps

package sha1sh_pkg;

   localparam int WORD_W        = 32;
   localparam int BLOCK_WORDS   = 16;
   localparam int CHAIN_WORDS   = 5;
   localparam int TOTAL_W       = 61;
   localparam int ROUND_W       = 7;
   localparam int IDX_W         = 3;

   localparam logic [ROUND_W-1:0] ROUND_LAST   = 7'd79;
   localparam logic [ROUND_W-1:0] ROUND_PHASE1 = 7'd20;
   localparam logic [ROUND_W-1:0] ROUND_PHASE2 = 7'd40;
   localparam logic [ROUND_W-1:0] ROUND_PHASE3 = 7'd60;

   localparam logic [IDX_W-1:0] LAST_WORD_IDX = 3'd4;

   localparam logic [5:0] POS_LAST     = 6'd63;
   localparam logic [5:0] POS_PAD_OVER = 6'd56;

   localparam logic [7:0] PAD_BYTE = 8'h80;

   localparam logic [WORD_W-1:0] K_0 = 32'h5A827999;
   localparam logic [WORD_W-1:0] K_1 = 32'h6ED9EBA1;
   localparam logic [WORD_W-1:0] K_2 = 32'h8F1BBCDC;
   localparam logic [WORD_W-1:0] K_3 = 32'hCA62C1D6;

   localparam logic [WORD_W-1:0] INIT_CHAIN [CHAIN_WORDS] = '{
      32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
   };

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0] digest_word;
      logic [IDX_W-1:0]  word_index;
      logic              final_word;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic             byte_wr;
      logic             comp_start;
      logic             round_en;
      logic             chain_add;
      logic             pad;
      logic             len_wr;
      logic             buf_clear;
      logic             emit_done;
      logic [IDX_W-1:0] emit_idx;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic pos_last;
      logic pad_over;
      logic round_last;
   } sts_type;

endpackage

@@ hdl/sha1_stream_hasher.sv @@
`timescale 1ns / 1ps

// SHA-1 hasher over a byte stream.
// Each req_ word may carry one message byte (byte_present) and may close the
// message (last_byte); a word with only last_byte closes the message without
// adding a byte. The five 32-bit words of the 160-bit digest leave on the
// rsp_ channel, most significant first, with word_index 0..4 and final_word
// on the last one.
// A byte word that does not complete a 64-byte block is taken while req_ready
// stays high. A byte that completes a block starts the compression: 80 rounds
// at one round per cycle, then the update of the chaining words, before the
// next word is taken. At the end of a message the padding adds one more
// compression (two when 56 or more bytes of the last block are used), each
// followed by the chaining update; rsp_valid rises when the last is done,
// after the compression of the block that the closing word completes, if it
// does. The digest words are then shown one per cycle
// while rsp_ready is high. req_ready stays low until the fifth digest word
// is taken; a stalled receiver holds the block with the current word on the
// port. Reset loads the initial chaining values and clears the byte count;
// the block accepts words in the cycle after reset is released.

module sha1_stream_hasher
   import sha1sh_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   cmd_type           cmd;
   sts_type           sts;
   logic [WORD_W-1:0] digest_word;

   sha1sh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   sha1sh_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .data_byte   (req_data.data_byte),
      .cmd         (cmd),
      .sts         (sts),
      .digest_word (digest_word)
   );

   assign rsp_data.digest_word = digest_word;
   assign rsp_data.word_index  = cmd.emit_idx;
   assign rsp_data.final_word  = (cmd.emit_idx == LAST_WORD_IDX);

endmodule

@@ hdl/sha1sh_datapath.sv @@
`timescale 1ns / 1ps

module sha1sh_datapath
   import sha1sh_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic [7:0]        data_byte,
   input  cmd_type           cmd,
   output sts_type           sts,
   output logic [WORD_W-1:0] digest_word
);

   logic [WORD_W-1:0]  w_ff     [BLOCK_WORDS];
   logic [WORD_W-1:0]  w_in     [BLOCK_WORDS];
   logic [WORD_W-1:0]  chain_ff [CHAIN_WORDS];
   logic [WORD_W-1:0]  chain_in [CHAIN_WORDS];
   logic [WORD_W-1:0]  work_ff  [CHAIN_WORDS];
   logic [WORD_W-1:0]  work_in  [CHAIN_WORDS];
   logic [TOTAL_W-1:0] total_ff;
   logic [TOTAL_W-1:0] total_in;
   logic [ROUND_W-1:0] round_ff;
   logic [ROUND_W-1:0] round_in;

   logic [5:0]        pos;
   logic [WORD_W-1:0] sched_new;
   logic [WORD_W-1:0] f_val;
   logic [WORD_W-1:0] k_val;
   logic [WORD_W-1:0] temp;

   assign pos = total_ff[5:0];

   assign sts.pos_last   = (pos == POS_LAST);
   assign sts.pad_over   = (pos >= POS_PAD_OVER);
   assign sts.round_last = (round_ff == ROUND_LAST);

   assign digest_word = chain_ff[cmd.emit_idx];

   // The buffer doubles as the rolling 16-word message schedule window.
   assign sched_new = {w_ff[13][WORD_W-2:0] ^ w_ff[8][WORD_W-2:0]
                       ^ w_ff[2][WORD_W-2:0] ^ w_ff[0][WORD_W-2:0],
                       w_ff[13][WORD_W-1] ^ w_ff[8][WORD_W-1]
                       ^ w_ff[2][WORD_W-1] ^ w_ff[0][WORD_W-1]};

   always_comb begin
      if (round_ff < ROUND_PHASE1) begin
         f_val = (work_ff[1] & work_ff[2]) | (~work_ff[1] & work_ff[3]);
         k_val = K_0;
      end else if (round_ff < ROUND_PHASE2) begin
         f_val = work_ff[1] ^ work_ff[2] ^ work_ff[3];
         k_val = K_1;
      end else if (round_ff < ROUND_PHASE3) begin
         f_val = (work_ff[1] & work_ff[2]) | (work_ff[1] & work_ff[3])
               | (work_ff[2] & work_ff[3]);
         k_val = K_2;
      end else begin
         f_val = work_ff[1] ^ work_ff[2] ^ work_ff[3];
         k_val = K_3;
      end
   end

   assign temp = {work_ff[0][WORD_W-6:0], work_ff[0][WORD_W-1:WORD_W-5]}
               + f_val + work_ff[4] + k_val + w_ff[0];

   always_comb begin
      w_in = w_ff;
      if (cmd.round_en) begin
         for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
            w_in[i] = w_ff[i+1];
         end
         w_in[BLOCK_WORDS-1] = sched_new;
      end
      if (cmd.byte_wr) begin
         w_in[pos[5:2]][{~pos[1:0], 3'b000} +: 8] = data_byte;
      end
      if (cmd.pad) begin
         // The end marker goes at the current position, zeros fill the rest.
         for (int i = 0; i < BLOCK_WORDS; i++) begin
            for (int j = 0; j < 4; j++) begin
               if (6'(4 * i + j) == pos) begin
                  w_in[i][WORD_W-1-8*j -: 8] = PAD_BYTE;
               end else if (6'(4 * i + j) > pos) begin
                  w_in[i][WORD_W-1-8*j -: 8] = 8'h00;
               end
            end
         end
      end
      if (cmd.buf_clear) begin
         for (int i = 0; i < BLOCK_WORDS; i++) begin
            w_in[i] = '0;
         end
      end
      if (cmd.len_wr) begin
         w_in[BLOCK_WORDS-2] = total_ff[TOTAL_W-1:TOTAL_W-WORD_W];
         w_in[BLOCK_WORDS-1] = {total_ff[TOTAL_W-WORD_W-1:0], 3'b000};
      end
   end

   always_comb begin
      work_in = work_ff;
      if (cmd.comp_start) begin
         work_in = chain_ff;
      end else if (cmd.round_en) begin
         work_in[4] = work_ff[3];
         work_in[3] = work_ff[2];
         work_in[2] = {work_ff[1][1:0], work_ff[1][WORD_W-1:2]};
         work_in[1] = work_ff[0];
         work_in[0] = temp;
      end
   end

   always_comb begin
      chain_in = chain_ff;
      total_in = total_ff;
      round_in = round_ff;
      if (cmd.chain_add) begin
         for (int i = 0; i < CHAIN_WORDS; i++) begin
            chain_in[i] = chain_ff[i] + work_ff[i];
         end
      end
      if (cmd.byte_wr) begin
         total_in = total_ff + TOTAL_W'(1);
      end
      if (cmd.emit_done) begin
         chain_in = INIT_CHAIN;
         total_in = '0;
      end
      if (cmd.comp_start) begin
         round_in = '0;
      end else if (cmd.round_en) begin
         round_in = round_ff + ROUND_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= INIT_CHAIN;
         total_ff <= '0;
         round_ff <= '0;
      end else begin
         chain_ff <= chain_in;
         total_ff <= total_in;
         round_ff <= round_in;
      end
   end

   always_ff @(posedge clock) begin
      w_ff    <= w_in;
      work_ff <= work_in;
   end

endmodule

@@ hdl/sha1sh_ctrl.sv @@
`timescale 1ns / 1ps

module sha1sh_ctrl
   import sha1sh_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  req_type req_data,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_ROUND,
      S_ADD,
      S_PAD,
      S_LEN,
      S_EMIT
   } state_type;

   // What follows the current compression.
   typedef enum logic [1:0] {
      N_IDLE,
      N_PAD,
      N_LEN,
      N_EMIT
   } next_type;

   state_type        state_ff, state_in;
   next_type         next_ff, next_in;
   logic [IDX_W-1:0] idx_ff, idx_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_EMIT);

   always_comb begin
      state_in = state_ff;
      next_in  = next_ff;
      idx_in   = idx_ff;
      cmd      = '0;
      cmd.emit_idx = idx_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.byte_wr = req_data.byte_present;
               if (req_data.byte_present && sts.pos_last) begin
                  cmd.comp_start = 1'b1;
                  state_in = S_ROUND;
                  next_in  = req_data.last_byte ? N_PAD : N_IDLE;
               end else if (req_data.last_byte) begin
                  state_in = S_PAD;
               end
            end
         end
         S_ROUND: begin
            cmd.round_en = 1'b1;
            if (sts.round_last) begin
               state_in = S_ADD;
            end
         end
         S_ADD: begin
            cmd.chain_add = 1'b1;
            unique case (next_ff)
               N_IDLE: state_in = S_IDLE;
               N_PAD:  state_in = S_PAD;
               N_LEN:  state_in = S_LEN;
               N_EMIT: begin
                  state_in = S_EMIT;
                  idx_in   = '0;
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_PAD: begin
            // Without room for the length, the padded block goes out first.
            cmd.pad        = 1'b1;
            cmd.comp_start = 1'b1;
            cmd.len_wr     = !sts.pad_over;
            next_in        = sts.pad_over ? N_LEN : N_EMIT;
            state_in       = S_ROUND;
         end
         S_LEN: begin
            cmd.buf_clear  = 1'b1;
            cmd.len_wr     = 1'b1;
            cmd.comp_start = 1'b1;
            next_in        = N_EMIT;
            state_in       = S_ROUND;
         end
         S_EMIT: begin
            if (rsp_ready) begin
               if (idx_ff == LAST_WORD_IDX) begin
                  cmd.emit_done = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         next_ff  <= N_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         next_ff  <= next_in;
         idx_ff   <= idx_in;
      end
   end

endmodule
